### hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, held off while reset is asserted.
`define SCPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define SCPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/scpa_pkg.sv
package scpa_pkg;

  localparam int SLOTS_PER_CLASS_DEF = 64;
  localparam int NUM_DEVICES_DEF     = 16;
  localparam int NUM_CLASSES         = 4;
  localparam int MAP_W               = 64;
  localparam int BYTES_W             = 40;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [2:0] CLASS_DIRECT      = 3'd4;
  localparam logic       KIND_ALLOC        = 1'b0;
  localparam logic       KIND_FREE         = 1'b1;
  localparam logic [6:0] FREE_SLOTS_DIRECT = 7'd64;

  typedef enum logic [1:0] {
    STAT_POOLED     = 2'd0,
    STAT_DIRECT     = 2'd1,
    STAT_FREED      = 2'd2,
    STAT_NOT_IN_USE = 2'd3
  } status_e;

  typedef struct packed {
    logic        kind;
    logic [3:0]  device;
    logic [31:0] size;
    logic [2:0]  size_class;
    logic [5:0]  slot;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [2:0]           granted_class;
    logic [5:0]           granted_slot;
    logic [31:0]          block_bytes;
    logic [BYTES_W-1:0]   device_total;
    logic [BYTES_W-1:0]   device_peak;
    logic [BYTES_W-1:0]   system_total;
    logic [31:0]          alloc_count;
    logic [31:0]          release_count;
    logic [6:0]           class_free_slots;
  } rsp_t;

  // Block size of a pooled class.
  function automatic logic [31:0] class_bytes(input logic [1:0] cls);
    logic [31:0] b;
    case (cls)
      2'd0:    b = 32'd4096;
      2'd1:    b = 32'd16384;
      2'd2:    b = 32'd65536;
      default: b = 32'd262144;
    endcase
    return b;
  endfunction

endpackage

### hdl/scpa_front.sv
module scpa_front #(
  parameter int NUM_DEVICES = scpa_pkg::NUM_DEVICES_DEF
) (
  input  logic          start,
  input  scpa_pkg::req_t req_i,
  input  logic          full_i,
  output logic          busy_o,
  output logic          push_o,
  output scpa_pkg::req_t push_data_o
);

  logic       dev_ok;
  logic [2:0] alloc_cls;

  assign dev_ok = 7'(req_i.device) < 7'(NUM_DEVICES);
  assign busy_o = full_i;

  // Pick the smallest class that fits; anything larger goes direct.
  always_comb begin
    if (req_i.size <= scpa_pkg::class_bytes(2'd0)) begin
      alloc_cls = 3'd0;
    end else if (req_i.size <= scpa_pkg::class_bytes(2'd1)) begin
      alloc_cls = 3'd1;
    end else if (req_i.size <= scpa_pkg::class_bytes(2'd2)) begin
      alloc_cls = 3'd2;
    end else if (req_i.size <= scpa_pkg::class_bytes(2'd3)) begin
      alloc_cls = 3'd3;
    end else begin
      alloc_cls = scpa_pkg::CLASS_DIRECT;
    end
  end

  always_comb begin
    push_data_o = req_i;
    if (req_i.kind == scpa_pkg::KIND_ALLOC) begin
      push_data_o.size_class = alloc_cls;
    end
  end

  // Drop requests for devices that do not exist.
  assign push_o = start && !full_i && dev_ok;

endmodule

### hdl/scpa_queue.sv
module scpa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scpa_pkg::req_t push_data_i,
  input  logic           pop_i,
  output scpa_pkg::req_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int DEPTH = scpa_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  scpa_pkg::req_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign empty_o = count_q == '0;
  assign full_o  = count_q == CNT_W'(DEPTH);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### hdl/scpa_back.sv
module scpa_back #(
  parameter int SLOTS_PER_CLASS = scpa_pkg::SLOTS_PER_CLASS_DEF,
  parameter int NUM_DEVICES     = scpa_pkg::NUM_DEVICES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  scpa_pkg::req_t head_i,
  output logic           pop_o,
  output logic           done_o,
  output scpa_pkg::rsp_t rsp_o
);

  localparam int BW         = scpa_pkg::BYTES_W;
  localparam int DEV_AW     = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int POOL_DEPTH = NUM_DEVICES * scpa_pkg::NUM_CLASSES;
  localparam int POOL_AW    = DEV_AW + 2;
  localparam logic [scpa_pkg::MAP_W-1:0] FULL_MASK =
    (SLOTS_PER_CLASS >= scpa_pkg::MAP_W) ? {scpa_pkg::MAP_W{1'b1}} :
    ((64'd1 << SLOTS_PER_CLASS) - 64'd1);

  typedef struct packed {
    logic [scpa_pkg::MAP_W-1:0] map;
    logic [6:0]                 cnt;
  } pool_word_t;

  typedef struct packed {
    logic [BW-1:0] total;
    logic [BW-1:0] peak;
    logic [31:0]   allocs;
    logic [31:0]   frees;
  } dev_rec_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e         state_q;
  scpa_pkg::req_t cur_q;
  logic           done_q;
  scpa_pkg::rsp_t rsp_q, rsp_d;
  logic [BW-1:0]  sys_q, sys_d;

  pool_word_t              pool_mem [POOL_DEPTH];
  logic [POOL_DEPTH-1:0]   pool_vld_q;
  pool_word_t              pool_rd_q, pool_wd, pw;
  logic                    pool_rv_q, pool_we;

  dev_rec_t                dev_mem [NUM_DEVICES];
  logic [NUM_DEVICES-1:0]  dev_vld_q;
  dev_rec_t                dev_rd_q, dev_wd, dr;
  logic                    dev_rv_q, dev_we;

  logic [DEV_AW-1:0]  head_dev, cur_dev;
  logic [POOL_AW-1:0] head_pidx, cur_pidx;
  logic               exec;

  logic [5:0]    low_slot;
  logic          do_charge, do_release;
  logic [31:0]   amt;
  logic [BW:0]   dev_sum, sys_sum;
  logic [BW-1:0] dev_add, dev_sub, sys_add, sys_sub;

  assign head_dev  = DEV_AW'(head_i.device);
  assign cur_dev   = DEV_AW'(cur_q.device);
  assign head_pidx = {head_dev, head_i.size_class[1:0]};
  assign cur_pidx  = {cur_dev, cur_q.size_class[1:0]};
  assign exec      = state_q == S_EXEC;
  assign pop_o     = (state_q == S_IDLE) && !empty_i;
  assign done_o    = done_q;
  assign rsp_o     = rsp_q;

  // Class bitmap and free count store.
  always_ff @(posedge clk_i) begin
    if (exec && pool_we) begin
      pool_mem[cur_pidx] <= pool_wd;
    end
    if (pop_o) begin
      pool_rd_q <= pool_mem[head_pidx];
    end
  end

  // Per-device counter store.
  always_ff @(posedge clk_i) begin
    if (exec && dev_we) begin
      dev_mem[cur_dev] <= dev_wd;
    end
    if (pop_o) begin
      dev_rd_q <= dev_mem[head_dev];
    end
  end

  // Entries never written read as their reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_vld_q <= '0;
      dev_vld_q  <= '0;
      pool_rv_q  <= 1'b0;
      dev_rv_q   <= 1'b0;
    end else begin
      if (exec && pool_we) begin
        pool_vld_q[cur_pidx] <= 1'b1;
      end
      if (exec && dev_we) begin
        dev_vld_q[cur_dev] <= 1'b1;
      end
      if (pop_o) begin
        pool_rv_q <= pool_vld_q[head_pidx];
        dev_rv_q  <= dev_vld_q[head_dev];
      end
    end
  end

  always_comb begin
    pw = pool_rv_q ? pool_rd_q : pool_word_t'{map: FULL_MASK, cnt: 7'(SLOTS_PER_CLASS)};
    dr = dev_rv_q ? dev_rd_q : '0;

    // Lowest free slot.
    low_slot = '0;
    for (int i = scpa_pkg::MAP_W - 1; i >= 0; i--) begin
      if (pw.map[i]) begin
        low_slot = 6'(i);
      end
    end

    pool_wd    = pw;
    pool_we    = 1'b0;
    do_charge  = 1'b0;
    do_release = 1'b0;
    amt        = '0;

    rsp_d                  = '0;
    rsp_d.status           = scpa_pkg::STAT_NOT_IN_USE;
    rsp_d.granted_class    = scpa_pkg::CLASS_DIRECT;
    rsp_d.class_free_slots = scpa_pkg::FREE_SLOTS_DIRECT;

    if (cur_q.kind == scpa_pkg::KIND_ALLOC) begin
      do_charge = 1'b1;
      if (cur_q.size_class != scpa_pkg::CLASS_DIRECT && pw.map != '0) begin
        pool_wd.map            = pw.map & ~(64'd1 << low_slot);
        pool_wd.cnt            = pw.cnt - 7'd1;
        pool_we                = 1'b1;
        rsp_d.status           = scpa_pkg::STAT_POOLED;
        rsp_d.granted_class    = cur_q.size_class;
        rsp_d.granted_slot     = low_slot;
        amt                    = scpa_pkg::class_bytes(cur_q.size_class[1:0]);
        rsp_d.class_free_slots = pw.cnt - 7'd1;
      end else begin
        rsp_d.status = scpa_pkg::STAT_DIRECT;
        amt          = cur_q.size;
      end
    end else if (cur_q.size_class == scpa_pkg::CLASS_DIRECT) begin
      do_release   = 1'b1;
      rsp_d.status = scpa_pkg::STAT_FREED;
      amt          = cur_q.size;
    end else if (cur_q.size_class > scpa_pkg::CLASS_DIRECT) begin
      rsp_d.granted_class = cur_q.size_class;
    end else begin
      rsp_d.granted_class    = cur_q.size_class;
      rsp_d.granted_slot     = cur_q.slot;
      rsp_d.class_free_slots = pw.cnt;
      if (!pw.map[cur_q.slot] && (7'(cur_q.slot) < 7'(SLOTS_PER_CLASS))) begin
        pool_wd.map            = pw.map | (64'd1 << cur_q.slot);
        pool_wd.cnt            = pw.cnt + 7'd1;
        pool_we                = 1'b1;
        do_release             = 1'b1;
        rsp_d.status           = scpa_pkg::STAT_FREED;
        amt                    = scpa_pkg::class_bytes(cur_q.size_class[1:0]);
        rsp_d.class_free_slots = pw.cnt + 7'd1;
      end
    end
    rsp_d.block_bytes = amt;

    // Saturating totals.
    dev_sum = {1'b0, dr.total} + (BW + 1)'(amt);
    sys_sum = {1'b0, sys_q} + (BW + 1)'(amt);
    dev_add = dev_sum[BW] ? {BW{1'b1}} : dev_sum[BW-1:0];
    sys_add = sys_sum[BW] ? {BW{1'b1}} : sys_sum[BW-1:0];
    dev_sub = (BW'(amt) >= dr.total) ? '0 : dr.total - BW'(amt);
    sys_sub = (BW'(amt) >= sys_q) ? '0 : sys_q - BW'(amt);

    dev_wd = dr;
    sys_d  = sys_q;
    if (do_charge) begin
      dev_wd.total  = dev_add;
      dev_wd.allocs = dr.allocs + 32'd1;
      dev_wd.peak   = (dev_add > dr.peak) ? dev_add : dr.peak;
      sys_d         = sys_add;
    end else if (do_release) begin
      dev_wd.total = dev_sub;
      dev_wd.frees = dr.frees + 32'd1;
      sys_d        = sys_sub;
    end
    dev_we = do_charge || do_release;

    rsp_d.device_total  = dev_wd.total;
    rsp_d.device_peak   = dev_wd.peak;
    rsp_d.system_total  = sys_d;
    rsp_d.alloc_count   = dev_wd.allocs;
    rsp_d.release_count = dev_wd.frees;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      sys_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            cur_q   <= head_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          rsp_q   <= rsp_d;
          done_q  <= 1'b1;
          sys_q   <= sys_d;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/size_class_pool_allocator.sv
// Slab allocator with four size classes per device. A request is taken when start is high
// and busy is low; a request for a device numbered NUM_DEVICES or above is taken and dropped
// with no result. Taken requests wait in a two-entry queue, and the back end works on them
// one at a time: in S_IDLE it pops a request and reads the class bitmap and the device
// counters, and in S_EXEC it updates them and registers the result. Because of the
// read-modify-write of those two stores, it pops no new request until the last is done.
// Each result shows on rsp_o for exactly one cycle with done_o high and is not held: the
// receiver must take it then. No clearing pass runs after reset; the block takes requests
// from the first cycle.
module size_class_pool_allocator #(
  parameter int SLOTS_PER_CLASS = scpa_pkg::SLOTS_PER_CLASS_DEF,
  parameter int NUM_DEVICES     = scpa_pkg::NUM_DEVICES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  scpa_pkg::req_t req_i,
  output logic           done_o,
  output scpa_pkg::rsp_t rsp_o
);

  logic           push, pop, q_empty, q_full;
  scpa_pkg::req_t push_data, head;

  scpa_front #(
    .NUM_DEVICES(NUM_DEVICES)
  ) u_front (
    .start      (start),
    .req_i      (req_i),
    .full_i     (q_full),
    .busy_o     (busy),
    .push_o     (push),
    .push_data_o(push_data)
  );

  scpa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  scpa_back #(
    .SLOTS_PER_CLASS(SLOTS_PER_CLASS),
    .NUM_DEVICES    (NUM_DEVICES)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(q_empty),
    .head_i (head),
    .pop_o  (pop),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

### hdl/scpa_checker.sv
`include "assert_macros.svh"

module scpa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input scpa_pkg::req_t req_i,
  input logic           done_o,
  input scpa_pkg::rsp_t rsp_o
);

  logic unused_inputs;
  assign unused_inputs = start ^ busy ^ (^req_i);

  // Each request passes S_IDLE and S_EXEC in the back end, so results never come back to back.
  `SCPA_ASSERT_ALWAYS(a_done_spaced, clk_i, done_o |=> !done_o, "results back to back")

  `SCPA_ASSERT(a_peak_bound, clk_i, rst_ni, done_o |-> rsp_o.device_peak >= rsp_o.device_total, "device total above peak")

  `SCPA_ASSERT(a_pooled_fields, clk_i, rst_ni, done_o && rsp_o.status == scpa_pkg::STAT_POOLED |-> rsp_o.granted_class < scpa_pkg::CLASS_DIRECT && rsp_o.class_free_slots < scpa_pkg::FREE_SLOTS_DIRECT, "pooled grant with bad class or count")

  `SCPA_ASSERT(a_reject_no_bytes, clk_i, rst_ni, done_o && rsp_o.status == scpa_pkg::STAT_NOT_IN_USE |-> rsp_o.block_bytes == '0, "rejected free moved bytes")

endmodule

bind size_class_pool_allocator scpa_checker u_scpa_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .req_i (req_i),
  .done_o(done_o),
  .rsp_o (rsp_o)
);
